### hdl/telemetry_frame_builder_unit_assert.svh
// assertion macros shared by the frame builder rtl
// no dependencies; files that assert include this header by name
`ifndef TELEMETRY_FRAME_BUILDER_UNIT_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define TFB_ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tfb assertion failed");
// consequent holds in the same cycle as the antecedent
`define TFB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfb assertion failed");
// consequent holds in the cycle after the antecedent
`define TFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfb assertion failed");
`else
`define TFB_ASSERT_HOLDS(lbl, clk, rst, expr)
`define TFB_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define TFB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/tfb_pkg.sv
// types and constants of the telemetry frame builder
// no dependencies; imported by every module of the block
package tfb_pkg;

   localparam int unsigned FRAME_LEN  = 31;
   localparam int unsigned WORD_COUNT = 7;
   localparam int unsigned SEQ_POS    = 29;
   localparam int unsigned CSUM_POS   = 30;
   localparam int unsigned BYTE_IDX_W = $clog2(FRAME_LEN);

   localparam logic [7:0] VERSION_BYTE = 8'h01;

   // register index, taken from paddr[2]
   localparam logic REG_SEND_INTERVAL  = 1'b0;
   localparam logic REG_TARGET_ADDRESS = 1'b1;

   typedef logic [BYTE_IDX_W-1:0] byte_idx_type;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      logic [31:0]                  now_ms;
      logic [WORD_COUNT-1:0][31:0]  words;
   } sample_type;

   typedef struct packed {
      logic [31:0] send_interval_ms;
      logic [31:0] target_address;
   } cfg_type;

   // handshake between frame queue and serializer
   typedef struct packed {
      logic valid;
      logic pop;
   } q_ctl_type;

endpackage

### hdl/tfb_front.sv
// front end: rate and address filter, sequence numbering, frame assembly
// depends on tfb_pkg
module tfb_front
   import tfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       push,
   input  sample_type sample,
   input  logic       q_full,
   output logic       q_push,
   output frame_type  q_frame
);

   logic [31:0] last_send_ff;
   logic [31:0] last_send_in;
   logic [7:0]  seq_ff;
   logic [7:0]  seq_in;
   logic [31:0] elapsed;
   logic        send_ok;
   logic        accept;
   frame_type   frame;
   logic [7:0]  csum;

   assign accept  = push && !q_full;
   assign elapsed = sample.now_ms - last_send_ff;
   assign send_ok = (elapsed >= cfg.send_interval_ms) && (cfg.target_address != 32'd0);
   assign q_push  = accept && send_ok;

   always_comb begin
      frame = '0;
      frame[0] = VERSION_BYTE;
      for (int k = 0; k < WORD_COUNT; k++) begin
         for (int b = 0; b < 4; b++) begin
            frame[1 + 4*k + b] = sample.words[k][8*b +: 8];
         end
      end
      frame[SEQ_POS] = seq_ff;
      csum = 8'd0;
      for (int i = 0; i < CSUM_POS; i++) begin
         csum = csum ^ frame[i];
      end
      frame[CSUM_POS] = csum;
   end

   assign q_frame = frame;

   always_comb begin
      last_send_in = last_send_ff;
      seq_in       = seq_ff;
      if (q_push) begin
         last_send_in = sample.now_ms;
         seq_in       = seq_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_send_ff <= 32'd0;
         seq_ff       <= 8'd0;
      end else begin
         last_send_ff <= last_send_in;
         seq_ff       <= seq_in;
      end
   end

endmodule

### hdl/tfb_queue.sv
// short queue of assembled frames between front end and serializer
// depends on tfb_pkg and the assertion header
`include "telemetry_frame_builder_unit_assert.svh"
module tfb_queue
   import tfb_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_in,
   input  frame_type frame_in,
   output logic      full,
   input  logic      pop_in,
   output logic      valid_out,
   output frame_type frame_out
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   frame_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign valid_out = (count_ff != '0);
   assign frame_out = slot_ff[rd_ptr_ff];
   assign do_push   = push_in && !full;
   assign do_pop    = pop_in && valid_out;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TFB_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNT_FULL)
   `TFB_ASSERT_IMPLY(a_no_pop_empty, clock, reset, count_ff == '0, !pop_in)
   `TFB_ASSERT_NEXT(a_push_counts, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

### hdl/tfb_serializer.sv
// back end: sends one frame byte per request, flags the checksum byte
// depends on tfb_pkg and the assertion header
`include "telemetry_frame_builder_unit_assert.svh"
module tfb_serializer
   import tfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  frame_type  q_frame,
   output q_ctl_type  q_ctl,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] frame_byte,
   output logic       last_byte
);

   localparam byte_idx_type LAST_IDX = BYTE_IDX_W'(CSUM_POS);

   frame_type    frame_ff;
   logic         busy_ff;
   logic         busy_in;
   byte_idx_type idx_ff;
   byte_idx_type idx_in;
   logic         is_last;
   logic         take;
   logic         load;

   assign is_last    = (idx_ff == LAST_IDX);
   assign take       = busy_ff && pop;
   assign load       = q_valid && (!busy_ff || (take && is_last));
   assign empty      = !busy_ff;
   assign frame_byte = frame_ff[idx_ff];
   assign last_byte  = is_last;
   assign q_ctl.valid = q_valid;
   assign q_ctl.pop   = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + BYTE_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= q_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   `TFB_ASSERT_IMPLY(a_idx_bound, clock, reset, busy_ff, idx_ff <= LAST_IDX)
   `TFB_ASSERT_NEXT(a_idx_step, clock, reset, take && !is_last, busy_ff && idx_ff == $past(idx_ff) + BYTE_IDX_W'(1))
   `TFB_ASSERT_NEXT(a_drain_idle, clock, reset, take && is_last && !q_valid, !busy_ff)

endmodule

### hdl/telemetry_frame_builder_unit.sv
// top level of the telemetry frame builder: config registers and wiring
// depends on tfb_pkg, tfb_front, tfb_queue, tfb_serializer
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------------------------
// request   | in        | push / full               | req_now_ms, req_quat_*, req_pos_*
// response  | out       | pop / empty               | rsp_frame_byte, rsp_last_byte
// config    | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// a request is taken in the cycle it arrives while the frame queue has room;
// the filter decision and the full 31-byte frame with checksum are made in that cycle
// each sent frame goes out as 31 bytes, one byte per pop from the serializer,
// which loads the next queued frame as the last byte of the current one is popped;
// full rises when QUEUE_DEPTH frames wait behind the one being sent; stalls on pop
// hold the current byte; synchronous reset clears filter state, sequence and queue
module telemetry_frame_builder_unit
   import tfb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_quat_w,
   input  logic [31:0] req_quat_x,
   input  logic [31:0] req_quat_y,
   input  logic [31:0] req_quat_z,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   // response channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   // config port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       cfg_wr;
   sample_type sample;
   logic       q_push;
   logic       q_full;
   frame_type  q_frame_in;
   frame_type  q_frame_out;
   q_ctl_type  q_ctl;
   logic       q_valid;

   // config registers, word address in paddr[2]
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (paddr[2])
            REG_SEND_INTERVAL:  cfg_in.send_interval_ms = pwdata;
            REG_TARGET_ADDRESS: cfg_in.target_address   = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SEND_INTERVAL:  prdata = cfg_ff.send_interval_ms;
         REG_TARGET_ADDRESS: prdata = cfg_ff.target_address;
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample words in frame order
   always_comb begin
      sample.now_ms   = req_now_ms;
      sample.words[0] = req_quat_w;
      sample.words[1] = req_quat_x;
      sample.words[2] = req_quat_y;
      sample.words[3] = req_quat_z;
      sample.words[4] = req_pos_x;
      sample.words[5] = req_pos_y;
      sample.words[6] = req_pos_z;
   end

   assign full = q_full;

   // front end: filter and assemble
   tfb_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .push    (push),
      .sample  (sample),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_frame (q_frame_in)
   );

   // decoupling queue of whole frames
   tfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (q_push),
      .frame_in  (q_frame_in),
      .full      (q_full),
      .pop_in    (q_ctl.pop),
      .valid_out (q_valid),
      .frame_out (q_frame_out)
   );

   // back end: byte serializer holding the response register
   tfb_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_frame    (q_frame_out),
      .q_ctl      (q_ctl),
      .empty      (empty),
      .pop        (pop),
      .frame_byte (rsp_frame_byte),
      .last_byte  (rsp_last_byte)
   );

endmodule

### test/tb_telemetry_frame_builder_unit.sv
// testbench of the telemetry frame builder: directed table, then random samples in three phases
// frames are predicted byte by byte and compared on every pop; depends on tfb_pkg and the rtl
`timescale 1ns / 100ps

module tb_telemetry_frame_builder_unit;
   import tfb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DIR_ROWS    = 21;
   localparam int unsigned PHASES      = 3;

   typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {EXP_NONE, EXP_DROP, EXP_SEND} row_expect_type;

   // one directed row: a register write, or a sample whose seven words are
   // the fill pattern rotated by four bits per word
   typedef struct packed {
      row_kind_type   kind;
      logic           reg_idx;
      logic [31:0]    value;
      logic [31:0]    fill;
      row_expect_type outcome;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_quat_w = '0;
   logic [31:0] req_quat_x = '0;
   logic [31:0] req_quat_y = '0;
   logic [31:0] req_quat_z = '0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // mirror of the block's registers and filter state
   logic [31:0] cfg_interval = '0;
   logic [31:0] cfg_target = '0;
   logic [31:0] last_send_ms = '0;
   logic [7:0]  next_seq = '0;

   frame_beat_type frame_bytes_due[$];
   frame_beat_type want_beat;
   bit             frame_sent;
   int unsigned    requests_taken = 0;
   int unsigned    fail_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    send_idle_pct = 35;
   int unsigned    recv_idle_pct = 81;

   dir_row_type dir_table [DIR_ROWS] = '{
      // target address still zero after reset
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'd0, 32'h0000_0000, EXP_DROP},
      '{ROW_CFG, REG_SEND_INTERVAL, 32'd100, 32'h0, EXP_NONE},
      '{ROW_CFG, REG_TARGET_ADDRESS, 32'hC0A8_0001, 32'h0, EXP_NONE},
      // last send time is zero after reset, so now below the interval drops
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'd99, 32'h0000_0000, EXP_DROP},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'd100, 32'h0000_0000, EXP_SEND},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'd199, 32'hFFFF_FFFF, EXP_DROP},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'hFFFF_FFF0, 32'hFFFF_FFFF, EXP_SEND},
      // timer wrap: difference of 0x20 is short of the interval
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_0010, 32'hA5A5_5A5A, EXP_DROP},
      // timer wrap: difference of exactly the interval
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_0054, 32'h0123_4567, EXP_SEND},
      '{ROW_CFG, REG_SEND_INTERVAL, 32'd0, 32'h0, EXP_NONE},
      // interval zero: same timestamp is sent again
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_0054, 32'h8000_0000, EXP_SEND},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_0000, 32'h7FFF_FFFF, EXP_SEND},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_1000, 32'h3F80_0000, EXP_NONE},
      '{ROW_CFG, REG_SEND_INTERVAL, 32'hFFFF_FFFF, 32'h0, EXP_NONE},
      // largest interval: only a difference of all ones gets through
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_0FFF, 32'hBF80_0000, EXP_SEND},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_1000, 32'h0000_0000, EXP_DROP},
      '{ROW_CFG, REG_TARGET_ADDRESS, 32'h0, 32'h0, EXP_NONE},
      '{ROW_CFG, REG_SEND_INTERVAL, 32'h0, 32'h0, EXP_NONE},
      // zero target blocks even with interval zero
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_2000, 32'hFFFF_FFFF, EXP_DROP},
      '{ROW_CFG, REG_TARGET_ADDRESS, 32'hFFFF_FFFF, 32'h0, EXP_NONE},
      '{ROW_SAMPLE, REG_SEND_INTERVAL, 32'h0000_2000, 32'hDEAD_BEEF, EXP_SEND}
   };

   // per random phase: interval, item count and idle percentages
   logic [31:0] phase_interval [PHASES] = '{32'd0, 32'd10, 32'd3};
   int unsigned phase_items    [PHASES] = '{120, 95, 95};
   int unsigned phase_send_idle[PHASES] = '{35, 81, 0};
   int unsigned phase_recv_idle[PHASES] = '{81, 35, 0};

   telemetry_frame_builder_unit DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_now_ms(req_now_ms),
      .req_quat_w(req_quat_w),
      .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .empty(empty),
      .pop(pop),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last_byte(rsp_last_byte),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // filter decision and frame assembly for one accepted request
   function automatic void queue_expected_frame(input sample_type s);
      frame_beat_type beat;
      logic [7:0]     csum;
      if ((s.now_ms - last_send_ms) < cfg_interval || cfg_target == 32'd0) begin
         frame_sent = 1'b0;
         return;
      end
      frame_sent   = 1'b1;
      last_send_ms = s.now_ms;
      beat.is_last = 1'b0;
      beat.data    = VERSION_BYTE;
      csum         = VERSION_BYTE;
      frame_bytes_due.push_back(beat);
      // words go out little-endian, in input order
      for (int k = 0; k < WORD_COUNT; k++) begin
         for (int b = 0; b < 4; b++) begin
            beat.data = s.words[k][8*b +: 8];
            csum      = csum ^ beat.data;
            frame_bytes_due.push_back(beat);
         end
      end
      beat.data = next_seq;
      csum      = csum ^ next_seq;
      frame_bytes_due.push_back(beat);
      next_seq     = next_seq + 8'd1;
      beat.data    = csum;
      beat.is_last = 1'b1;
      frame_bytes_due.push_back(beat);
   endfunction

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_telemetry_frame_builder_unit NOT OK");
         $finish;
      end
   end

   // receiver: pop stalls at random per cycle
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: compare popped bytes first, then predict the request taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (frame_bytes_due.size() == 0) begin
               $error("response with no frame byte pending: byte %h last %b",
                      rsp_frame_byte, rsp_last_byte);
               fail_count = fail_count + 1;
            end else begin
               want_beat = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== want_beat.data) begin
                  $error("frame_byte: expected %h, got %h", want_beat.data, rsp_frame_byte);
                  fail_count = fail_count + 1;
               end
               if (rsp_last_byte !== want_beat.is_last) begin
                  $error("last_byte: expected %b, got %b", want_beat.is_last, rsp_last_byte);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SEND_INTERVAL)
               cfg_interval = pwdata;
            else
               cfg_target = pwdata;
         end
         if (push && !full) begin
            queue_expected_frame('{req_now_ms, {req_pos_z, req_pos_y, req_pos_x,
               req_quat_z, req_quat_y, req_quat_x, req_quat_w}});
            requests_taken = requests_taken + 1;
         end
      end
   end

   // present one request after random idle cycles and hold it until taken
   task automatic send_sample(input sample_type s);
      int unsigned want_count;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push       <= 1'b1;
      req_now_ms <= s.now_ms;
      req_quat_w <= s.words[0];
      req_quat_x <= s.words[1];
      req_quat_y <= s.words[2];
      req_quat_z <= s.words[3];
      req_pos_x  <= s.words[4];
      req_pos_y  <= s.words[5];
      req_pos_z  <= s.words[6];
      want_count = requests_taken + 1;
      wait (requests_taken == want_count);
   endtask

   // stop requesting and let every predicted byte come out
   task automatic drain;
      @(negedge clock);
      push <= 1'b0;
      wait (frame_bytes_due.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // write a register, then read it back
   task automatic write_reg(input logic idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== value) begin
         $error("prdata: expected %h, got %h", value, prdata);
         fail_count = fail_count + 1;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      sample_type  s;
      logic [63:0] rot;
      logic [31:0] now;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].kind == ROW_CFG) begin
            drain();
            write_reg(dir_table[r].reg_idx, dir_table[r].value);
         end else begin
            s.now_ms = dir_table[r].value;
            for (int k = 0; k < WORD_COUNT; k++) begin
               rot        = {dir_table[r].fill, dir_table[r].fill} >> (4 * k);
               s.words[k] = rot[31:0];
            end
            send_sample(s);
            if ((dir_table[r].outcome == EXP_SEND && !frame_sent) ||
                (dir_table[r].outcome == EXP_DROP && frame_sent)) begin
               $error("sent: expected %b, got %b", dir_table[r].outcome == EXP_SEND,
                      frame_sent);
               fail_count = fail_count + 1;
            end
         end
      end

      // random phases; timestamps mostly step forward around the interval
      now = 32'h0000_2000;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         send_idle_pct = phase_send_idle[p];
         recv_idle_pct = phase_recv_idle[p];
         write_reg(REG_SEND_INTERVAL, phase_interval[p]);
         write_reg(REG_TARGET_ADDRESS, (p == 1) ? 32'd1 : $urandom_range(32'hFFFF_FFFF, 1));
         for (int i = 0; i < phase_items[p]; i++) begin
            if ($urandom_range(15) == 0)
               now = $urandom;
            else
               now = now + $urandom_range(4 * phase_interval[p], 0);
            s.now_ms = now;
            for (int k = 0; k < WORD_COUNT; k++) begin
               case ($urandom_range(9))
                  0: s.words[k] = 32'h0000_0000;
                  1: s.words[k] = 32'hFFFF_FFFF;
                  default: s.words[k] = $urandom;
               endcase
            end
            send_sample(s);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb_telemetry_frame_builder_unit OK");
      else
         $display("tb_telemetry_frame_builder_unit NOT OK");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/tfb_pkg.sv
hdl/tfb_front.sv
hdl/tfb_queue.sv
hdl/tfb_serializer.sv
hdl/telemetry_frame_builder_unit.sv
test/tb_telemetry_frame_builder_unit.sv
